// File: hw/rtl/crcfd_pkg.sv
// ----------------------------------------------------------------------------
// crcfd_pkg: shared types and constants of the CRC-32 frame deframer
// Parser phases, the operation codes that the parser queues for the checker,
// the status codes, and the bytewise reflected CRC-32 update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfd_pkg;

  // Frame markers and CRC constants.
  localparam logic [7:0]  HDR_FIRST  = 8'h55;
  localparam logic [7:0]  HDR_SECOND = 8'hAA;
  localparam logic [7:0]  FTR_FIRST  = 8'hAA;
  localparam logic [7:0]  FTR_SECOND = 8'h55;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES   = 32'hFFFF_FFFF;

  // Depth of the operation queue between parser and checker.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC    = 3'd4,
    PH_FTR_A  = 3'd5,
    PH_FTR_B  = 3'd6
  } phase_t;

  // Operations handed from the parser to the checker.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_CRC   = 2'd2,
    OP_END   = 2'd3
  } op_code_t;

  // Frame status codes.
  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_CRC_BAD    = 2'd1,
    ST_FOOTER_BAD = 2'd2
  } frame_status_t;

  // One queued operation.
  typedef struct packed {
    op_code_t   code;
    logic [7:0] data;    // payload or CRC byte
    logic [1:0] idx;     // byte position within the received CRC
    logic       ftr_ok;  // both footer bytes matched (end operation only)
  } op_t;

  // One result held in the output register.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_status;
    logic [1:0] frame_status;
  } result_t;

  // Reflected CRC-32 update over one byte, unrolled over its eight bits.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/crcfd_if.sv
// ----------------------------------------------------------------------------
// crcfd_if: stream channels of the deframer
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------
`default_nettype none

// Received byte channel.
interface crcfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: payload bytes and frame status items.
interface crcfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_status;
  logic [1:0] frame_status;

  modport source (output valid, output payload_byte, output is_status,
                  output frame_status, input ready);
  modport sink   (input valid, input payload_byte, input is_status,
                  input frame_status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/crc32_frame_deframer_core.sv
// Path: a byte transfer writes its operation into the queue; the checker loads the
// output register when it pops that operation, which stays queued while the output
// register is full and not being drained.
// Throughput: one received byte per cycle while the queue has room; CRC is bytewise.
// Reset (rst_n low, synchronous): parser returns to header hunt, queue and
// output register empty, CRC register all ones.
// ----------------------------------------------------------------------------
// crc32_frame_deframer_core: length-prefixed frame deframer with CRC-32
// Parser front end, operation queue, and CRC checker back end.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_frame_deframer_core (
  input  wire logic     clk,
  input  wire logic     rst_n,
  crcfd_in_if.sink      in_ch,
  crcfd_out_if.source   out_ch
);
  import crcfd_pkg::*;

  logic q_push;
  op_t  q_push_op;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  op_t  q_head_op;

  // Front end: header hunt and field tracking.
  crcfd_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (q_push_op)
  );

  // Queue between front and back.
  crcfd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  // Back end: CRC, verdict and result register.
  crcfd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (q_head_valid),
    .op       (q_head_op),
    .op_pop   (q_pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// File: hw/rtl/crcfd_parser.sv
// ----------------------------------------------------------------------------
// crcfd_parser: front end of the deframer
// Hunts for the header, tracks length and field position, and queues one
// operation for each byte that the checker has to act on.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfd_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  crcfd_in_if.sink             in_ch,
  input  wire logic            q_full,
  output logic                 q_push,
  output crcfd_pkg::op_t       q_op
);
  import crcfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        ftr_ok_r, ftr_ok_nxt;
  logic        accept;
  logic        push_req;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic [7:0]  b;

  // A byte is taken whenever the queue has room.
  assign in_ch.ready = ~q_full;
  assign accept      = in_ch.valid & ~q_full;
  assign b           = in_ch.rx_byte;
  assign cnt_inc     = cnt_r + 16'd1;
  assign len_full    = {b, len_r[7:0]};
  assign q_push      = accept & push_req;

  // Phase and field registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      prev_r   <= 8'h00;
      len_r    <= 16'h0000;
      cnt_r    <= 16'h0000;
      ftr_ok_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      prev_r   <= prev_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      ftr_ok_r <= ftr_ok_nxt;
    end
  end

  // Next phase and the operation queued for this byte.
  always_comb begin
    phase_nxt   = phase_r;
    prev_nxt    = prev_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    ftr_ok_nxt  = ftr_ok_r;
    push_req    = 1'b0;
    q_op.code   = OP_START;
    q_op.data   = b;
    q_op.idx    = cnt_r[1:0];
    q_op.ftr_ok = 1'b0;
    case (phase_r)
      PH_LEN_LO: begin
        len_nxt   = {8'h00, b};
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = len_full;
        cnt_nxt   = 16'h0000;
        phase_nxt = (len_full == 16'h0000) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        push_req  = 1'b1;
        q_op.code = OP_DATA;
        if (cnt_inc == len_r) begin
          cnt_nxt   = 16'h0000;
          phase_nxt = PH_CRC;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_CRC: begin
        push_req  = 1'b1;
        q_op.code = OP_CRC;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = 16'h0000;
          phase_nxt = PH_FTR_A;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_FTR_A: begin
        ftr_ok_nxt = (b == FTR_FIRST);
        phase_nxt  = PH_FTR_B;
      end
      PH_FTR_B: begin
        push_req    = 1'b1;
        q_op.code   = OP_END;
        q_op.ftr_ok = ftr_ok_r & (b == FTR_SECOND);
        phase_nxt   = PH_HUNT;
        prev_nxt    = 8'h00;
        ftr_ok_nxt  = 1'b0;
      end
      default: begin
        // Hunting; unused phase codes behave the same way.
        if (prev_r == HDR_FIRST && b == HDR_SECOND) begin
          push_req   = 1'b1;
          q_op.code  = OP_START;
          phase_nxt  = PH_LEN_LO;
          prev_nxt   = 8'h00;
          len_nxt    = 16'h0000;
          cnt_nxt    = 16'h0000;
          ftr_ok_nxt = 1'b0;
        end else begin
          phase_nxt = PH_HUNT;
          prev_nxt  = b;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/crcfd_fifo.sv
// ----------------------------------------------------------------------------
// crcfd_fifo: operation queue between parser and checker
// A short first-in first-out queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfd_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  crcfd_pkg::op_t       push_op,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output crcfd_pkg::op_t       head_op
);
  import crcfd_pkg::*;

  op_t                slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = slot_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/crcfd_checker.sv
// ----------------------------------------------------------------------------
// crcfd_checker: back end of the deframer
// Runs the CRC over payload bytes, gathers the received CRC, judges the frame
// and drives the result channel from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfd_checker (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            op_valid,
  input  crcfd_pkg::op_t       op,
  output logic                 op_pop,
  crcfd_out_if.source          out_ch
);
  import crcfd_pkg::*;

  logic [31:0]   crc_r, crc_nxt;
  logic [31:0]   rcv_r, rcv_nxt;
  result_t       res_r, res_nxt;
  logic          res_valid_r;
  logic          emits;
  logic          out_free;
  frame_status_t status;

  assign emits    = (op.code == OP_DATA) || (op.code == OP_END);
  assign out_free = ~res_valid_r | out_ch.ready;
  assign op_pop   = op_valid & (~emits | out_free);

  // Result channel drive.
  assign out_ch.valid        = res_valid_r;
  assign out_ch.payload_byte = res_r.payload_byte;
  assign out_ch.is_status    = res_r.is_status;
  assign out_ch.frame_status = res_r.frame_status;

  // Frame verdict; a bad footer outranks a CRC mismatch.
  always_comb begin
    if (!op.ftr_ok) begin
      status = ST_FOOTER_BAD;
    end else if ((crc_r ^ CRC_ONES) != rcv_r) begin
      status = ST_CRC_BAD;
    end else begin
      status = ST_GOOD;
    end
  end

  // Work for the operation at the head of the queue.
  always_comb begin
    crc_nxt = crc_r;
    rcv_nxt = rcv_r;
    res_nxt = '{payload_byte: 8'h00, is_status: 1'b0, frame_status: ST_GOOD};
    case (op.code)
      OP_START: begin
        crc_nxt = CRC_ONES;
        rcv_nxt = 32'h0000_0000;
      end
      OP_DATA: begin
        crc_nxt              = crc_byte(crc_r, op.data);
        res_nxt.payload_byte = op.data;
      end
      OP_CRC: begin
        rcv_nxt = rcv_r | ({24'h0, op.data} << {op.idx, 3'b000});
      end
      OP_END: begin
        res_nxt.is_status    = 1'b1;
        res_nxt.frame_status = status;
      end
      default: begin
        crc_nxt = crc_r;
      end
    endcase
  end

  // CRC state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_ONES;
      rcv_r <= 32'h0000_0000;
    end else if (op_pop) begin
      crc_r <= crc_nxt;
      rcv_r <= rcv_nxt;
    end
  end

  // Output register; it refills in the same cycle that a transfer drains it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (op_pop && emits) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && emits) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire
